@@ rtl/core/dpr_pkg.sv @@
// Shared types and constants for the int8 dot product requantizer.
`timescale 1ns / 1ps

package dpr_pkg;

  // Operand layout
  localparam int FIELD_BITS = 64;
  localparam int BYTE_BITS  = 8;
  localparam int MAX_LANES  = FIELD_BITS / BYTE_BITS;
  localparam int PROD_BITS  = 2 * BYTE_BITS;

  // Accumulator and scaling
  localparam int SUM_BITS   = 32;
  localparam int MULT_BITS  = 31;
  localparam int SHIFT_BITS = 6;
  localparam int SCALED_BITS = SUM_BITS + MULT_BITS - 1;  // product stays below 2^62

  // Output range; a scaled magnitude at or above SAT_MAG clamps either way
  localparam int OUT_BITS = 8;
  localparam int ZP_BITS  = 8;
  localparam int OUT_MIN  = -128;
  localparam int OUT_MAX  = 127;
  localparam int SAT_MAG  = 256;
  localparam int MAG_BITS = 9;
  localparam int VAL_BITS = 11;

  // Register file
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  typedef enum logic [1:0] {
    REG_SCALE_MULT = 2'd0,
    REG_SCALE_SHIFT = 2'd1,
    REG_ZERO_POINT = 2'd2
  } dpr_reg_e;

  localparam logic [MULT_BITS-1:0]  RST_SCALE_MULT  = 31'd1073741824;
  localparam logic [SHIFT_BITS-1:0] RST_SCALE_SHIFT = 6'd31;
  localparam logic [ZP_BITS-1:0]    RST_ZERO_POINT  = 8'd0;

  typedef struct packed {
    logic [MULT_BITS-1:0]      scale_multiplier;
    logic [SHIFT_BITS-1:0]     scale_shift;
    logic signed [ZP_BITS-1:0] output_zero_point;
  } dpr_cfg_t;

endpackage

@@ rtl/core/dpr_regs.sv @@
// APB register file holding the requantization settings.
`timescale 1ns / 1ps

module dpr_regs
  import dpr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output dpr_cfg_t                 cfg
);

  dpr_cfg_t cfg_q;
  logic     wr_en;
  dpr_reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = dpr_reg_e'(paddr[APB_ADDR_BITS-1:2]);
  assign cfg    = cfg_q;

  // Register writes; unmapped addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.scale_multiplier  <= RST_SCALE_MULT;
      cfg_q.scale_shift       <= RST_SCALE_SHIFT;
      cfg_q.output_zero_point <= RST_ZERO_POINT;
    end else if (wr_en) begin
      case (idx)
        REG_SCALE_MULT:  cfg_q.scale_multiplier  <= pwdata[MULT_BITS-1:0];
        REG_SCALE_SHIFT: cfg_q.scale_shift       <= pwdata[SHIFT_BITS-1:0];
        REG_ZERO_POINT:  cfg_q.output_zero_point <= pwdata[ZP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (idx)
      REG_SCALE_MULT:  prdata = {{(APB_DATA_BITS-MULT_BITS){1'b0}}, cfg_q.scale_multiplier};
      REG_SCALE_SHIFT: prdata = {{(APB_DATA_BITS-SHIFT_BITS){1'b0}}, cfg_q.scale_shift};
      REG_ZERO_POINT:  prdata = {{(APB_DATA_BITS-ZP_BITS){1'b0}}, cfg_q.output_zero_point};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/dpr_lanes.sv @@
// Input register, per-lane byte multipliers and chunk adder tree.
`timescale 1ns / 1ps

module dpr_lanes
  import dpr_pkg::*;
#(
  parameter int NL = 8,
  parameter int CW = 19
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FIELD_BITS-1:0] in_a,
  input  logic [FIELD_BITS-1:0] in_b,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [CW-1:0]  out_sum,
  output logic                  out_last
);

  // stage 0: operands
  logic                  v0, l0;
  logic [FIELD_BITS-1:0] a0, b0;
  // stage 1: products
  logic                         v1, l1;
  logic signed [PROD_BITS-1:0]  prod1 [NL];
  logic signed [PROD_BITS-1:0]  prod_c [NL];
  // stage 2: chunk sum
  logic                 v2, l2;
  logic signed [CW-1:0] sum2, sum_c;
  logic                 rdy0, rdy1, rdy2;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  assign out_valid = v2;
  assign out_sum   = sum2;
  assign out_last  = l2;

  // signed byte products, exact including -128 * -128
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      prod_c[i] = $signed(a0[i*BYTE_BITS +: BYTE_BITS]) * $signed(b0[i*BYTE_BITS +: BYTE_BITS]);
    end
  end

  // add the lane products
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NL; i++) begin
      sum_c = sum_c + CW'(prod1[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      a0 <= in_a;
      b0 <= in_b;
      l0 <= in_last;
    end
    if (rdy1 && v0) begin
      prod1 <= prod_c;
      l1    <= l0;
    end
    if (rdy2 && v1) begin
      sum2 <= sum_c;
      l2   <= l1;
    end
  end

endmodule

@@ rtl/core/dpr_accum.sv @@
// Wrapping 32-bit running sum; passes the total on at the last chunk.
`timescale 1ns / 1ps

module dpr_accum
  import dpr_pkg::*;
#(
  parameter int CW = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [CW-1:0] in_sum,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SUM_BITS-1:0] out_total
);

  logic [SUM_BITS-1:0] running_sum, running_sum_next;
  logic [SUM_BITS-1:0] total_c, total;
  logic                v, rdy_out, take;

  assign rdy_out   = !v || out_ready;
  // non-last chunks only touch the sum, so they never wait on the output
  assign in_ready  = !in_last || rdy_out;
  assign take      = in_valid && in_ready;
  assign total_c   = running_sum + SUM_BITS'(in_sum);
  assign running_sum_next = in_last ? '0 : total_c;

  assign out_valid = v;
  assign out_total = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      v           <= 1'b0;
    end else begin
      if (take) running_sum <= running_sum_next;
      if (rdy_out) v <= in_valid && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && in_valid && in_last) total <= total_c;
  end

endmodule

@@ rtl/core/dpr_requant.sv @@
// Requantization pipeline: magnitude, scale multiply, shift, zero point, clamp.
`timescale 1ns / 1ps

module dpr_requant
  import dpr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  dpr_cfg_t                   cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SUM_BITS-1:0]        in_total,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] out_value
);

  // stage A: sign and magnitude
  logic                v4, neg4;
  logic [SUM_BITS-1:0] mag4;
  // stage B: scaled product
  logic                   v5, neg5;
  logic [SCALED_BITS-1:0] prod5, prod_c;
  // stage C: shifted magnitude, saturated to SAT_MAG
  logic                   v6, neg6;
  logic [MAG_BITS-1:0]    mag6, mag_c;
  logic [SCALED_BITS-1:0] shifted_c;
  // stage D: output register
  logic                       v7;
  logic signed [OUT_BITS-1:0] res7, res_c;
  logic signed [VAL_BITS-1:0] sv_c, diff_c;
  logic                       rdy4, rdy5, rdy6, rdy7;

  assign rdy7     = !v7 || out_ready;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign in_ready = rdy4;

  assign out_valid = v7;
  assign out_value = res7;

  // mantissa multiply; the magnitude is at most 2^31
  assign prod_c = SCALED_BITS'(mag4) * SCALED_BITS'(cfg.scale_multiplier);

  // shift truncates the magnitude; anything past SAT_MAG clamps the same
  assign shifted_c = prod5 >> cfg.scale_shift;
  assign mag_c = (shifted_c >= SCALED_BITS'(SAT_MAG)) ? MAG_BITS'(SAT_MAG)
                                                      : shifted_c[MAG_BITS-1:0];

  // restore sign, remove zero point, clamp
  always_comb begin
    sv_c   = $signed({{(VAL_BITS-MAG_BITS){1'b0}}, mag6});
    if (neg6) sv_c = -sv_c;
    diff_c = sv_c - VAL_BITS'(cfg.output_zero_point);
    if (diff_c < VAL_BITS'(OUT_MIN)) begin
      res_c = OUT_BITS'(OUT_MIN);
    end else if (diff_c > VAL_BITS'(OUT_MAX)) begin
      res_c = OUT_BITS'(OUT_MAX);
    end else begin
      res_c = diff_c[OUT_BITS-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      neg4 <= in_total[SUM_BITS-1];
      mag4 <= in_total[SUM_BITS-1] ? (~in_total + 1'b1) : in_total;
    end
    if (rdy5 && v4) begin
      neg5  <= neg4;
      prod5 <= prod_c;
    end
    if (rdy6 && v5) begin
      neg6 <= neg5;
      mag6 <= mag_c;
    end
    if (rdy7 && v6) begin
      res7 <= res_c;
    end
  end

endmodule

@@ rtl/core/int8_dot_product_requantize.sv @@
// Top level of the int8 dot product with fixed-point requantization.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata[63:0] a_lanes, [127:64] b_lanes;
//                                    s_tlast last_chunk
//  m_*      out  m_tvalid/m_tready   m_tdata[7:0] result_value
//  apb      in   psel/penable        paddr 0x0 scale_multiplier, 0x4 scale_shift,
//                                    0x8 output_zero_point
//
// One chunk is accepted per cycle while s_tready is high. A last chunk passes eight
// registers: operand, product, chunk-sum, accumulate, magnitude, scale multiply,
// shift and clamp. Its result shows on m_tvalid from the clamp register.
// Reset clears the running sum and empties the pipeline; settings return to defaults.
// A stalled m_tready holds the result; each stage keeps taking items while any
// later stage has room, and non-last chunks fold into the running sum regardless.
`timescale 1ns / 1ps

module int8_dot_product_requantize
  import dpr_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // input items
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [2*FIELD_BITS-1:0]  s_tdata,   // a_lanes, b_lanes
  input  logic                     s_tlast,   // last_chunk
  // result items
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_BITS-1:0]      m_tdata,   // result_value
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // lanes past the operand width carry no bits
  localparam int NL = (LANES < MAX_LANES) ? LANES : MAX_LANES;
  localparam int CW = PROD_BITS + $clog2(NL);

  dpr_cfg_t                   cfg;
  logic                       ch_valid, ch_ready, ch_last;
  logic signed [CW-1:0]       ch_sum;
  logic                       tot_valid, tot_ready;
  logic [SUM_BITS-1:0]        tot_value;
  logic signed [OUT_BITS-1:0] res_value;

  dpr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpr_lanes #(
    .NL (NL),
    .CW (CW)
  ) u_lanes (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_a      (s_tdata[FIELD_BITS-1:0]),
    .in_b      (s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .in_last   (s_tlast),
    .out_valid (ch_valid),
    .out_ready (ch_ready),
    .out_sum   (ch_sum),
    .out_last  (ch_last)
  );

  dpr_accum #(
    .CW (CW)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ch_valid),
    .in_ready  (ch_ready),
    .in_sum    (ch_sum),
    .in_last   (ch_last),
    .out_valid (tot_valid),
    .out_ready (tot_ready),
    .out_total (tot_value)
  );

  dpr_requant u_requant (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (tot_valid),
    .in_ready  (tot_ready),
    .in_total  (tot_value),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (res_value)
  );

  assign m_tdata = res_value;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the int8 dot product requantizer: stream driver, monitor, scoreboard.
`timescale 1ns / 1ps

module tb;
  import dpr_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RST_CYCLES    = 6;
  localparam int PIPE_DEPTH    = 8;
  localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int LIMIT_CYCLES  = 200_000;
  localparam int PHASE_ITEMS   = 150;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED = 4'hC;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_e;
  typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_SPARSE} fill_e;

  typedef struct {
    logic [FIELD_BITS-1:0] a_lanes;
    logic [FIELD_BITS-1:0] b_lanes;
    logic                  last_chunk;
  } chunk_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [2*FIELD_BITS-1:0]  s_tdata = '0;  // a_lanes, b_lanes
  logic                     s_tlast = 1'b0;  // last_chunk
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_BITS-1:0]      m_tdata;  // result_value
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Shadow of the block's settings and accumulator
  logic [MULT_BITS-1:0]      cfg_mult  = RST_SCALE_MULT;
  logic [SHIFT_BITS-1:0]     cfg_shift = RST_SCALE_SHIFT;
  logic signed [ZP_BITS-1:0] cfg_zp    = RST_ZERO_POINT;
  logic [SUM_BITS-1:0]       dot_sum   = '0;

  chunk_t                     pending_chunks[$];
  logic signed [OUT_BITS-1:0] expected_elems[$];

  int errors = 0;
  int chunks_accepted = 0;
  int elems_checked = 0;
  int dots_queued = 0;
  int reg_writes = 0;
  int settings_used = 1;
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  chunk_t next_chunk;

  int8_dot_product_requantize u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Sum of the exact signed byte products of one chunk, sign extended to the sum width
  function automatic logic [SUM_BITS-1:0] chunk_dot(input logic [FIELD_BITS-1:0] a,
                                                    input logic [FIELD_BITS-1:0] b);
    logic [SUM_BITS-1:0] s;
    logic signed [BYTE_BITS-1:0] x;
    logic signed [BYTE_BITS-1:0] y;
    logic signed [PROD_BITS-1:0] p;
    s = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      x = a[i*BYTE_BITS +: BYTE_BITS];
      y = b[i*BYTE_BITS +: BYTE_BITS];
      p = x * y;
      s = s + {{(SUM_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
    end
    return s;
  endfunction

  // Scale on the magnitude, truncate toward zero, restore sign, remove zero point, clamp
  function automatic logic signed [OUT_BITS-1:0] requant_elem(input logic [SUM_BITS-1:0] sum);
    logic neg;
    logic [63:0] mag;
    logic [63:0] scaled;
    logic signed [63:0] v;
    neg = sum[SUM_BITS-1];
    mag = {32'd0, neg ? (~sum + 32'd1) : sum};
    scaled = (mag * {33'd0, cfg_mult}) >> cfg_shift;
    v = neg ? -$signed(scaled) : $signed(scaled);
    v = v - cfg_zp;
    if (v < OUT_MIN) begin
      v = OUT_MIN;
    end else if (v > OUT_MAX) begin
      v = OUT_MAX;
    end
    return v[OUT_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] fill_lanes(input fill_e fill);
    logic [FIELD_BITS-1:0] w;
    w = {$urandom, $urandom};
    for (int i = 0; i < MAX_LANES; i++) begin
      if (fill == FILL_EXTREME) begin
        case ($urandom_range(0, 5))
          0: w[i*BYTE_BITS +: BYTE_BITS] = 8'h80;
          1: w[i*BYTE_BITS +: BYTE_BITS] = 8'h7F;
          2: w[i*BYTE_BITS +: BYTE_BITS] = 8'h81;
          3: w[i*BYTE_BITS +: BYTE_BITS] = 8'hFF;
          4: w[i*BYTE_BITS +: BYTE_BITS] = 8'h00;
          default: w[i*BYTE_BITS +: BYTE_BITS] = 8'h01;
        endcase
      end else if (fill == FILL_SPARSE && $urandom_range(0, 2) != 0) begin
        w[i*BYTE_BITS +: BYTE_BITS] = '0;
      end
    end
    return w;
  endfunction

  task automatic push_chunk(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b,
                            input logic last);
    chunk_t c;
    c.a_lanes = a;
    c.b_lanes = b;
    c.last_chunk = last;
    pending_chunks.push_back(c);
    if (last) dots_queued++;
  endtask

  // Well-formed dot products of mostly short length, a few long ones
  task automatic push_random_dots(input int n_items);
    int count;
    int len;
    int pick;
    fill_e fill;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      pick = $urandom_range(0, 9);
      fill = (pick < 6) ? FILL_RANDOM : (pick < 8) ? FILL_EXTREME : FILL_SPARSE;
      for (int k = 0; k < len; k++) begin
        push_chunk(fill_lanes(fill), fill_lanes(fill), k == len - 1);
      end
      count += len;
    end
  endtask

  task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input dpr_reg_e r, input logic [APB_DATA_BITS-1:0] data);
    apb_write({r, 2'b00}, data);
    case (r)
      REG_SCALE_MULT:  cfg_mult  = data[MULT_BITS-1:0];
      REG_SCALE_SHIFT: cfg_shift = data[SHIFT_BITS-1:0];
      REG_ZERO_POINT:  cfg_zp    = data[ZP_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [APB_DATA_BITS-1:0] mult,
                            input logic [APB_DATA_BITS-1:0] shift,
                            input logic [APB_DATA_BITS-1:0] zp);
    write_reg(REG_SCALE_MULT, mult);
    write_reg(REG_SCALE_SHIFT, shift);
    write_reg(REG_ZERO_POINT, zp);
    settings_used++;
    @(negedge clk);
  endtask

  // All items accepted, all results back, pipeline flushed of non-last chunks
  task automatic wait_idle();
    int n;
    @(negedge clk);
    while (pending_chunks.size() != 0 || s_tvalid) @(negedge clk);
    n = 0;
    while (expected_elems.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Fold an accepted chunk into the predicted sum; a last chunk yields one element
  task automatic fold_chunk(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b,
                            input logic last);
    dot_sum = dot_sum + chunk_dot(a, b);
    if (last) begin
      expected_elems.push_back(requant_elem(dot_sum));
      dot_sum = '0;
    end
  endtask

  // Driver: bursts of items with random gaps, long gap-free stretches now and then
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        fold_chunk(s_tdata[FIELD_BITS-1:0], s_tdata[2*FIELD_BITS-1:FIELD_BITS], s_tlast);
        chunks_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_chunks.size() != 0) begin
          next_chunk = pending_chunks.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {next_chunk.b_lanes, next_chunk.a_lanes};
          s_tlast  <= next_chunk.last_chunk;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 24);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each element against the oldest prediction, then pick next tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_elems.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   $signed(m_tdata));
          errors++;
        end else begin
          if (m_tdata !== expected_elems[0]) begin
            $display("%0t: result %0d mismatch, expected %0d, actual %0d", $time,
                     elems_checked, expected_elems[0], $signed(m_tdata));
            errors++;
          end
          void'(expected_elems.pop_front());
        end
        elems_checked++;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(32, 256);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               expected_elems.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: extremes of the bytes, truncation toward zero, lane order, cancellation
    push_chunk('0, '0, 1'b1);
    push_chunk({8{8'h80}}, {8{8'h80}}, 1'b1);
    push_chunk({8{8'h80}}, {8{8'h7F}}, 1'b1);
    push_chunk({8{8'h81}}, {8{8'h81}}, 1'b1);
    push_chunk(64'h00000000000000FF, 64'h01, 1'b1);
    push_chunk(64'h00000000000000FD, 64'h01, 1'b1);
    for (int i = 0; i < MAX_LANES; i++) begin
      push_chunk({56'd0, 8'(i + 1)} << (BYTE_BITS * i), 64'h02 << (BYTE_BITS * i),
                 i == MAX_LANES - 1);
    end
    push_chunk({8{8'h7F}}, {8{8'h7F}}, 1'b0);
    push_chunk({8{8'h7F}}, {8{8'h81}}, 1'b0);
    push_chunk(64'h01, 64'hFB, 1'b1);
    push_random_dots(PHASE_ITEMS);
    wait_idle();

    // Largest scale, no shift, lowest zero point; upper pwdata bits set to check masking
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFC0, 32'hFFFF_FF80);
    push_chunk('0, '0, 1'b1);
    push_chunk({8{8'h80}}, {8{8'h7F}}, 1'b1);
    push_chunk(64'h01, 64'h01, 1'b1);
    push_random_dots(PHASE_ITEMS);
    wait_idle();

    // Zero scale, widest stated shift, highest zero point
    set_config(32'h0, 32'd62, 32'd127);
    push_random_dots(PHASE_ITEMS);
    wait_idle();

    // Shift of 63 beyond the stated range; a write past the last register must be ignored
    set_config($urandom, 32'd63, $urandom);
    apb_write(ADDR_UNMAPPED, $urandom);
    @(negedge clk);
    push_random_dots(PHASE_ITEMS);
    wait_idle();

    // Random settings that keep most results inside the output range
    repeat (4) begin
      set_config($urandom, $urandom_range(34, 46), $urandom);
      push_random_dots(PHASE_ITEMS);
      wait_idle();
    end

    if (expected_elems.size() != 0) begin
      $display("%0t: %0d expected results never arrived, oldest expected %0d, actual none",
               $time, expected_elems.size(), expected_elems[0]);
      errors += expected_elems.size();
    end
    $display("Run covered %0d chunks in %0d dot products, %0d results checked, %0d errors.",
             chunks_accepted, dots_queued, elems_checked, errors);
    $display("Settings: %0d register writes over %0d scale settings, stalls on both sides.",
             reg_writes, settings_used);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ int8_dot_product_requantize.f @@
rtl/core/dpr_pkg.sv
rtl/core/dpr_regs.sv
rtl/core/dpr_lanes.sv
rtl/core/dpr_accum.sv
rtl/core/dpr_requant.sv
rtl/core/int8_dot_product_requantize.sv
verif/tb.sv
